/* design/pinhole_primary_ray_direction_core_macros.svh */
// assertion macros shared by the pinhole ray direction design
// depends on nothing; included by the modules that carry assertions
`ifndef PINHOLE_PRIMARY_RAY_DIRECTION_CORE_MACROS_SVH
`define PINHOLE_PRIMARY_RAY_DIRECTION_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PRDC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PRDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/prdc_pkg.sv */
// shared types and constants of the pinhole ray direction core
// depends on nothing
package prdc_pkg;

    localparam int WIN_W     = 24;
    localparam int DIST_W    = 23;
    localparam int BASIS_W   = 48;
    localparam int COMP_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MAG_W     = 30;
    localparam int SUM_W     = 2 * MAG_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int FRAC_W    = 14;
    localparam int QUO_W     = 15;
    localparam int OUT_W     = 16;

    localparam logic [WIN_W-1:0]   WIN_LO_RESET  = WIN_W'(-104858);
    localparam logic [WIN_W-1:0]   WIN_HI_RESET  = WIN_W'(104858);
    localparam logic [DIST_W-1:0]  DIST_RESET    = DIST_W'(104858);
    localparam logic [BASIS_W-1:0] RIGHT_RESET   = BASIS_W'(48'd16384);
    localparam logic [BASIS_W-1:0] UP_RESET      = BASIS_W'(48'd16384 << 16);
    localparam logic [BASIS_W-1:0] BACK_RESET    = BASIS_W'(48'd16384 << 32);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LEFT,
        REG_WINDOW_RIGHT,
        REG_WINDOW_BOTTOM,
        REG_WINDOW_TOP,
        REG_VIEW_DISTANCE,
        REG_BASIS_RIGHT,
        REG_BASIS_UP,
        REG_BASIS_BACK
    } t_reg_idx;

    // normalized magnitudes with their signs
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  zero;
    } t_norm_vec;

endpackage

/* design/prdc_ifs.sv */
// handshake channels of the pinhole ray direction core
// depends on prdc_pkg
interface prdc_pix_if import prdc_pkg::*; #(parameter int PIXEL_INDEX_BITS = 12);
    logic                        valid;
    logic                        ready;
    logic [PIXEL_INDEX_BITS-1:0] pixel_col;
    logic [PIXEL_INDEX_BITS-1:0] pixel_row;
    logic [PIXEL_INDEX_BITS:0]   image_width;
    logic [PIXEL_INDEX_BITS:0]   image_height;
    modport source (output valid, pixel_col, pixel_row, image_width, image_height,
                    input ready);
    modport sink   (input valid, pixel_col, pixel_row, image_width, image_height,
                    output ready);
endinterface

interface prdc_dir_if import prdc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] dir_x;
    logic signed [OUT_W-1:0] dir_y;
    logic signed [OUT_W-1:0] dir_z;
    modport source (output valid, dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface prdc_cfg_if import prdc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BASIS_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/pinhole_primary_ray_direction_core.sv */
// channel   dir  payload
// i_cfg     in   index (3b), data (48b): camera window, distance, basis
// i_pix     in   pixel_col, pixel_row, image_width, image_height
// o_dir     out  dir_x, dir_y, dir_z, signed Q2.14
//
// one item per cycle unless a full output buffer freezes the pipeline; on the way to o_dir
// an item passes 4 front, 5 normalize, 31 square root, 17 divide stages, output register;
// the square root and divide bit-per-stage chains set the depth.
// synchronous active-low reset clears valid bits and loads camera defaults.
// a two-deep output buffer keeps i_pix ready while one result waits;
// the pipeline freezes only when both entries are full.
// top level: config registers, pipeline, output buffer
// depends on prdc_pkg, the channel interfaces, the stage modules and macros
`include "pinhole_primary_ray_direction_core_macros.svh"
module pinhole_primary_ray_direction_core import prdc_pkg::*; #(
    parameter int PIXEL_INDEX_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prdc_cfg_if.sink   i_cfg,
    prdc_pix_if.sink   i_pix,
    prdc_dir_if.source o_dir
);
    localparam int E_W = PIXEL_INDEX_BITS + 46;

    logic [WIN_W-1:0]     r_win_l, r_win_r, r_win_b, r_win_t;
    logic [DIST_W-1:0]    r_dist;
    logic [BASIS_W-1:0]   r_right, r_up, r_back;

    logic                 en;
    logic                 f_vld, n_vld, s_vld, p_vld;
    logic [2:0][E_W-1:0]  f_e;
    t_norm_vec            n_vec, s_vec;
    logic [SUM_W-1:0]     n_sum;
    logic [ROOT_W-1:0]    s_root;
    logic [2:0][OUT_W-1:0] p_dir;

    logic                 r_ov, r_sv;
    logic [2:0][OUT_W-1:0] r_o, r_s;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_l <= WIN_LO_RESET;
            r_win_r <= WIN_HI_RESET;
            r_win_b <= WIN_LO_RESET;
            r_win_t <= WIN_HI_RESET;
            r_dist  <= DIST_RESET;
            r_right <= RIGHT_RESET;
            r_up    <= UP_RESET;
            r_back  <= BACK_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_WINDOW_LEFT:   r_win_l <= i_cfg.data[WIN_W-1:0];
                REG_WINDOW_RIGHT:  r_win_r <= i_cfg.data[WIN_W-1:0];
                REG_WINDOW_BOTTOM: r_win_b <= i_cfg.data[WIN_W-1:0];
                REG_WINDOW_TOP:    r_win_t <= i_cfg.data[WIN_W-1:0];
                REG_VIEW_DISTANCE: r_dist  <= i_cfg.data[DIST_W-1:0];
                REG_BASIS_RIGHT:   r_right <= i_cfg.data;
                REG_BASIS_UP:      r_up    <= i_cfg.data;
                REG_BASIS_BACK:    r_back  <= i_cfg.data;
            endcase
        end
    end

    // the whole pipeline advances unless the buffer entry is taken
    assign en          = !r_sv;
    assign i_pix.ready = en;

    prdc_front #(
        .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS),
        .E_W              (E_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_pix.valid),
        .i_col    (i_pix.pixel_col),
        .i_row    (i_pix.pixel_row),
        .i_width  (i_pix.image_width),
        .i_height (i_pix.image_height),
        .i_win_l  (r_win_l),
        .i_win_r  (r_win_r),
        .i_win_b  (r_win_b),
        .i_win_t  (r_win_t),
        .i_dist   (r_dist),
        .i_right  (r_right),
        .i_up     (r_up),
        .i_back   (r_back),
        .o_vld    (f_vld),
        .o_e      (f_e)
    );

    prdc_norm #(.E_W(E_W)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_e     (f_e),
        .o_vld   (n_vld),
        .o_vec   (n_vec),
        .o_sum   (n_sum)
    );

    prdc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (n_vld),
        .i_vec   (n_vec),
        .i_sum   (n_sum),
        .o_vld   (s_vld),
        .o_vec   (s_vec),
        .o_root  (s_root)
    );

    prdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_vld),
        .i_vec   (s_vec),
        .i_root  (s_root),
        .o_vld   (p_vld),
        .o_dir   (p_dir)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || o_dir.ready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= p_vld;
            end
        end else if (p_vld && en) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || o_dir.ready) begin
            r_o <= r_sv ? r_s : p_dir;
        end else if (p_vld && en) begin
            r_s <= p_dir;
        end
    end

    assign o_dir.valid = r_ov;
    assign o_dir.dir_x = r_o[0];
    assign o_dir.dir_y = r_o[1];
    assign o_dir.dir_z = r_o[2];

    `PRDC_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_sv, r_ov, "buffered item without a shown item")
endmodule

/* design/prdc_front.sv */
// screen offsets and basis combination: four stages from pixel to the exact vector
// depends on prdc_pkg
module prdc_front import prdc_pkg::*; #(
    parameter int PIXEL_INDEX_BITS = 12,
    parameter int E_W = PIXEL_INDEX_BITS + 46
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [PIXEL_INDEX_BITS-1:0] i_col,
    input  logic [PIXEL_INDEX_BITS-1:0] i_row,
    input  logic [PIXEL_INDEX_BITS:0]   i_width,
    input  logic [PIXEL_INDEX_BITS:0]   i_height,
    input  logic [WIN_W-1:0]            i_win_l,
    input  logic [WIN_W-1:0]            i_win_r,
    input  logic [WIN_W-1:0]            i_win_b,
    input  logic [WIN_W-1:0]            i_win_t,
    input  logic [DIST_W-1:0]           i_dist,
    input  logic [BASIS_W-1:0]          i_right,
    input  logic [BASIS_W-1:0]          i_up,
    input  logic [BASIS_W-1:0]          i_back,
    output logic                        o_vld,
    output logic [2:0][E_W-1:0]         o_e
);
    localparam int P     = PIXEL_INDEX_BITS;
    localparam int PW    = P + 27;
    localparam int SU_W  = P + 28;
    localparam int PRD_W = SU_W + COMP_W;

    logic [P:0]               w_fix, h_fix;
    logic signed [WIN_W:0]    dx, dy;
    logic signed [P+1:0]      odd_c, odd_r;

    logic signed [PW-1:0]     r_lw, r_dc, r_bh, r_dr;
    logic [DIST_W+P:0]        r_dh;
    logic signed [SU_W-1:0]   r_su, r_sv, r_dd;
    logic signed [PRD_W-1:0]  r_pr [3];
    logic signed [PRD_W-1:0]  r_pu [3];
    logic signed [PRD_W-1:0]  r_pb [3];
    logic [2:0][E_W-1:0]      r_e;
    logic [3:0]               r_vld;

    // zero size counts as one
    assign w_fix = (i_width == '0)  ? (P+1)'(1) : i_width;
    assign h_fix = (i_height == '0) ? (P+1)'(1) : i_height;
    assign dx    = $signed({i_win_r[WIN_W-1], i_win_r}) - $signed({i_win_l[WIN_W-1], i_win_l});
    assign dy    = $signed({i_win_t[WIN_W-1], i_win_t}) - $signed({i_win_b[WIN_W-1], i_win_b});
    assign odd_c = $signed({1'b0, i_col, 1'b1});
    assign odd_r = $signed({1'b0, i_row, 1'b1});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lw <= PW'($signed(i_win_l) * $signed({1'b0, w_fix}));
            r_bh <= PW'($signed(i_win_b) * $signed({1'b0, h_fix}));
            r_dc <= PW'(dx * odd_c);
            r_dr <= PW'(dy * odd_r);
            r_dh <= i_dist * h_fix;
            r_su <= SU_W'(r_lw <<< 1) + SU_W'(r_dc);
            r_sv <= SU_W'(r_bh <<< 1) + SU_W'(r_dr);
            r_dd <= $signed({3'b000, r_dh, 1'b0});
            for (int k = 0; k < 3; k++) begin
                r_pr[k] <= PRD_W'(r_su * $signed(i_right[COMP_W*k +: COMP_W]));
                r_pu[k] <= PRD_W'(r_sv * $signed(i_up[COMP_W*k +: COMP_W]));
                r_pb[k] <= PRD_W'(r_dd * $signed(i_back[COMP_W*k +: COMP_W]));
                r_e[k]  <= E_W'(r_pr[k]) + E_W'(r_pu[k]) - E_W'(r_pb[k]);
            end
        end
    end

    assign o_vld = r_vld[3];
    assign o_e   = r_e;
endmodule

/* design/prdc_norm.sv */
// block normalization of the vector and its sum of squares, five stages
// depends on prdc_pkg and the assertion macros
`include "pinhole_primary_ray_direction_core_macros.svh"
module prdc_norm import prdc_pkg::*; #(
    parameter int E_W = 58
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [2:0][E_W-1:0] i_e,
    output logic                o_vld,
    output t_norm_vec           o_vec,
    output logic [SUM_W-1:0]    o_sum
);
    localparam int POS_W = $clog2(E_W);
    localparam logic [POS_W-1:0] TOP_POS = POS_W'(MAG_W - 1);

    logic [2:0][E_W-1:0]      r_mag, r_mag2;
    logic [2:0]               r_neg, r_neg2;
    logic [E_W-1:0]           r_or;
    logic [POS_W-1:0]         r_pos, pos;
    logic                     r_zero2;
    t_norm_vec                r_vec3, r_vec4, r_vec5, n_vec3;
    logic [2*MAG_W-1:0]       r_sq [3];
    logic [SUM_W-1:0]         r_sum;
    logic [4:0]               r_vld;

    always_comb begin
        pos = '0;
        for (int i = 0; i < E_W; i++) begin
            if (r_or[i]) begin
                pos = POS_W'(i);
            end
        end
    end

    // shift all three together so the largest lands in [2^29, 2^30)
    always_comb begin
        n_vec3.neg  = r_neg2;
        n_vec3.zero = r_zero2;
        for (int k = 0; k < 3; k++) begin
            if (r_pos > TOP_POS) begin
                n_vec3.mag[k] = MAG_W'(r_mag2[k] >> (r_pos - TOP_POS));
            end else begin
                n_vec3.mag[k] = MAG_W'(r_mag2[k] << (TOP_POS - r_pos));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= i_e[k][E_W-1];
                r_mag[k] <= i_e[k][E_W-1] ? (E_W'(0) - i_e[k]) : i_e[k];
                r_sq[k]  <= r_vec3.mag[k] * r_vec3.mag[k];
            end
            r_or    <= (i_e[0][E_W-1] ? (E_W'(0) - i_e[0]) : i_e[0])
                     | (i_e[1][E_W-1] ? (E_W'(0) - i_e[1]) : i_e[1])
                     | (i_e[2][E_W-1] ? (E_W'(0) - i_e[2]) : i_e[2]);
            r_mag2  <= r_mag;
            r_neg2  <= r_neg;
            r_pos   <= pos;
            r_zero2 <= (r_or == '0);
            r_vec3  <= n_vec3;
            r_vec4  <= r_vec3;
            r_vec5  <= r_vec4;
            r_sum   <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        end
    end

    assign o_vld = r_vld[4];
    assign o_vec = r_vec5;
    assign o_sum = r_sum;

    `PRDC_ASSERT_NOW(a_norm_range, i_clk, i_rst_n, r_vld[2] && !r_vec3.zero, r_vec3.mag[0][MAG_W-1] || r_vec3.mag[1][MAG_W-1] || r_vec3.mag[2][MAG_W-1], "normalized vector has no top bit set")
endmodule

/* design/prdc_sqrt.sv */
// floor square root, one result bit per stage
// depends on prdc_pkg
module prdc_sqrt import prdc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  t_norm_vec         i_vec,
    input  logic [SUM_W-1:0]  i_sum,
    output logic              o_vld,
    output t_norm_vec         o_vec,
    output logic [ROOT_W-1:0] o_root
);
    localparam int STEPS = ROOT_W;
    localparam int RW    = ROOT_W + 3;

    logic [SUM_W-1:0]  r_x    [STEPS];
    logic [RW-1:0]     r_rem  [STEPS];
    logic [ROOT_W-1:0] r_root [STEPS];
    t_norm_vec         r_vec  [STEPS];
    logic              r_vld  [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic [SUM_W-1:0]  x_in;
        logic [RW-1:0]     rem_in, cat, trial;
        logic [ROOT_W-1:0] root_in;
        t_norm_vec         vec_in;
        logic              vld_in;

        if (s == 0) begin : g_first
            assign x_in    = i_sum;
            assign rem_in  = '0;
            assign root_in = '0;
            assign vec_in  = i_vec;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign x_in    = r_x[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign vec_in  = r_vec[s-1];
            assign vld_in  = r_vld[s-1];
        end

        assign cat   = {rem_in[RW-3:0], x_in[SUM_W-1-2*s -: 2]};
        assign trial = {1'b0, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s]   <= x_in;
                r_vec[s] <= vec_in;
                if (cat >= trial) begin
                    r_rem[s]  <= cat - trial;
                    r_root[s] <= {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= cat;
                    r_root[s] <= {root_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_vec  = r_vec[STEPS-1];
    assign o_root = r_root[STEPS-1];
endmodule

/* design/prdc_div.sv */
// rounded quotient of each magnitude by the norm, three lanes, one bit per stage
// depends on prdc_pkg and the assertion macros
`include "pinhole_primary_ray_direction_core_macros.svh"
module prdc_div import prdc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  t_norm_vec               i_vec,
    input  logic [ROOT_W-1:0]       i_root,
    output logic                    o_vld,
    output logic [2:0][OUT_W-1:0]   o_dir
);
    localparam int NUM_W = MAG_W + FRAC_W + 1;

    logic [2:0][NUM_W-1:0]  r_num;
    logic [ROOT_W-1:0]      r_den0;
    t_norm_vec              r_vec0;
    logic                   r_vld0;

    logic [2:0][NUM_W-1:0]  r_rem  [QUO_W];
    logic [2:0][QUO_W-1:0]  r_q    [QUO_W];
    logic [ROOT_W-1:0]      r_den  [QUO_W];
    t_norm_vec              r_vec  [QUO_W];
    logic                   r_vld  [QUO_W];

    logic [2:0][OUT_W-1:0]  r_dir;
    logic                   r_vld_out;

    // magnitude scaled to Q2.14 plus half the divisor for rounding
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= {1'b0, i_vec.mag[k], FRAC_W'(0)} + NUM_W'(i_root >> 1);
            end
            r_den0 <= i_root;
            r_vec0 <= i_vec;
        end
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        localparam int B = QUO_W - 1 - s;
        logic [2:0][NUM_W-1:0] rem_in;
        logic [2:0][QUO_W-1:0] q_in;
        logic [ROOT_W-1:0]     den_in;
        logic [NUM_W-1:0]      dsh;
        t_norm_vec             vec_in;
        logic                  vld_in;

        if (s == 0) begin : g_first
            assign rem_in = r_num;
            assign q_in   = '0;
            assign den_in = r_den0;
            assign vec_in = r_vec0;
            assign vld_in = r_vld0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign q_in   = r_q[s-1];
            assign den_in = r_den[s-1];
            assign vec_in = r_vec[s-1];
            assign vld_in = r_vld[s-1];
        end

        assign dsh = NUM_W'(den_in) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= den_in;
                r_vec[s] <= vec_in;
                for (int k = 0; k < 3; k++) begin
                    if (rem_in[k] >= dsh) begin
                        r_rem[s][k] <= rem_in[k] - dsh;
                        r_q[s][k]   <= q_in[k] | (QUO_W'(1) << B);
                    end else begin
                        r_rem[s][k] <= rem_in[k];
                        r_q[s][k]   <= q_in[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0    <= 1'b0;
            r_vld_out <= 1'b0;
        end else if (i_en) begin
            r_vld0    <= i_vld;
            r_vld_out <= r_vld[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                if (r_vec[QUO_W-1].zero) begin
                    r_dir[k] <= '0;
                end else if (r_vec[QUO_W-1].neg[k]) begin
                    r_dir[k] <= OUT_W'(0) - OUT_W'(r_q[QUO_W-1][k]);
                end else begin
                    r_dir[k] <= OUT_W'(r_q[QUO_W-1][k]);
                end
            end
        end
    end

    assign o_vld = r_vld_out;
    assign o_dir = r_dir;

    `PRDC_ASSERT_NOW(a_quo_x, i_clk, i_rst_n, r_vld[QUO_W-1] && !r_vec[QUO_W-1].zero, r_q[QUO_W-1][0] <= QUO_W'(16384), "x quotient above one")
    `PRDC_ASSERT_NOW(a_quo_z, i_clk, i_rst_n, r_vld[QUO_W-1] && !r_vec[QUO_W-1].zero, r_q[QUO_W-1][2] <= QUO_W'(16384), "z quotient above one")
endmodule

/* sim/tb_top.sv */
// testbench for the pinhole ray direction core: directed and random pixels
// checked against an in-bench fixed-point predictor of the unit direction
// depends on prdc_pkg, the channel interfaces and the core
`timescale 1ns / 1ps
module tb_top;
    import prdc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    bit   quiet;   // no idling on either side

    prdc_cfg_if cfg_ch ();
    prdc_pix_if #(.PIXEL_INDEX_BITS(12)) pix_ch ();
    prdc_dir_if dir_ch ();

    pinhole_primary_ray_direction_core #(.PIXEL_INDEX_BITS(12)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_pix  (pix_ch.sink),
        .o_dir  (dir_ch.source)
    );

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] z;
    } t_dir;

    // camera registers as the predictor sees them
    logic [WIN_W-1:0]   cam_left, cam_right, cam_bottom, cam_top;
    logic [DIST_W-1:0]  cam_dist;
    logic [BASIS_W-1:0] cam_rt, cam_up, cam_back;

    t_dir expected_dirs[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("** pinhole_primary_ray_direction_core: FAILED **");
        $finish;
    end

    task automatic report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t",
                 what, $signed(got), $signed(want), $realtime);
        errors++;
    endtask

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint basis_comp(logic [BASIS_W-1:0] v, int k);
        logic signed [COMP_W-1:0] c;
        c = v[16*k +: 16];
        return longint'(c);
    endfunction

    function automatic t_dir ray_direction(logic [11:0] col, logic [11:0] row,
                                           logic [12:0] wd, logic [12:0] ht);
        longint w, h, lf, rt, bt, tp, su, sv, dd, e;
        longint unsigned mag[3], maxm, sum, nrm, q;
        bit neg[3];
        logic [OUT_W-1:0] o[3];
        t_dir r;
        w  = (wd == 0) ? 1 : longint'(wd);
        h  = (ht == 0) ? 1 : longint'(ht);
        lf = longint'($signed(cam_left));
        rt = longint'($signed(cam_right));
        bt = longint'($signed(cam_bottom));
        tp = longint'($signed(cam_top));
        su = 2 * lf * w + (rt - lf) * (2 * longint'(col) + 1);
        sv = 2 * bt * h + (tp - bt) * (2 * longint'(row) + 1);
        dd = longint'(cam_dist) * 2 * h;
        maxm = 0;
        for (int k = 0; k < 3; k++) begin
            e = su * basis_comp(cam_rt, k) + sv * basis_comp(cam_up, k)
                - dd * basis_comp(cam_back, k);
            neg[k] = e < 0;
            mag[k] = neg[k] ? -e : e;
            if (mag[k] > maxm) maxm = mag[k];
        end
        if (maxm == 0) return '0;
        while (maxm >= (64'd1 << 30)) begin
            maxm >>= 1;
            for (int k = 0; k < 3; k++) mag[k] >>= 1;
        end
        while (maxm < (64'd1 << 29)) begin
            maxm <<= 1;
            for (int k = 0; k < 3; k++) mag[k] <<= 1;
        end
        sum = 0;
        for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
        nrm = isqrt(sum);
        for (int k = 0; k < 3; k++) begin
            q = (mag[k] * 16384 + nrm / 2) / nrm;
            if (neg[k]) q = -q;
            o[k] = q[15:0];
        end
        r.x = o[0];
        r.y = o[1];
        r.z = o[2];
        return r;
    endfunction

    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(t_reg_idx idx, logic [BASIS_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_WINDOW_LEFT:   cam_left   = val[WIN_W-1:0];
            REG_WINDOW_RIGHT:  cam_right  = val[WIN_W-1:0];
            REG_WINDOW_BOTTOM: cam_bottom = val[WIN_W-1:0];
            REG_WINDOW_TOP:    cam_top    = val[WIN_W-1:0];
            REG_VIEW_DISTANCE: cam_dist   = val[DIST_W-1:0];
            REG_BASIS_RIGHT:   cam_rt     = val;
            REG_BASIS_UP:      cam_up     = val;
            default:           cam_back   = val;
        endcase
        @(posedge i_clk);
    endtask

    // sender holds valid across back-to-back items; lowered only on a gap
    task automatic send_pixel(logic [11:0] col, logic [11:0] row,
                              logic [12:0] wd, logic [12:0] ht);
        pix_ch.valid        <= 1'b1;
        pix_ch.pixel_col    <= col;
        pix_ch.pixel_row    <= row;
        pix_ch.image_width  <= wd;
        pix_ch.image_height <= ht;
        do @(posedge i_clk); while (!pix_ch.ready);
        expected_dirs.push_back(ray_direction(col, row, wd, ht));
        if (!quiet && $urandom_range(0, 5) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic end_stream();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (expected_dirs.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    // receiver with random stall bursts
    initial begin
        dir_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                dir_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            dir_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_dir want;
        if (i_rst_n && dir_ch.valid && dir_ch.ready) begin
            if (expected_dirs.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end else begin
                want = expected_dirs.pop_front();
                if (dir_ch.dir_x !== want.x) report("dir_x", dir_ch.dir_x, want.x);
                if (dir_ch.dir_y !== want.y) report("dir_y", dir_ch.dir_y, want.y);
                if (dir_ch.dir_z !== want.z) report("dir_z", dir_ch.dir_z, want.z);
            end
        end
    end

    function automatic logic [BASIS_W-1:0] rand_basis();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    task automatic test_defaults();
        send_pixel(0, 0, 1, 1);
        send_pixel(12'hfff, 12'hfff, 13'd4096, 13'd4096);
        send_pixel(0, 12'hfff, 13'd4096, 13'd1);
        send_pixel(12'hfff, 0, 13'd1, 13'd4096);
        send_pixel(100, 200, 13'd0, 13'd0);        // zero size read as one
        send_pixel(12'hfff, 12'hfff, 13'h1fff, 13'h1fff);
        send_pixel(639, 479, 640, 480);
        send_pixel(320, 240, 640, 480);
        send_pixel(12'haaa, 12'h555, 13'haaa, 13'h1555);
        send_pixel(12'h555, 12'haaa, 13'h1555, 13'haaa);
        end_stream();
        drain();
    endtask

    task automatic test_extremes();
        // widest window, reversed window, and all-zero vector
        write_reg(REG_WINDOW_LEFT, BASIS_W'(24'h800000));
        write_reg(REG_WINDOW_RIGHT, BASIS_W'(24'h7fffff));
        write_reg(REG_WINDOW_BOTTOM, BASIS_W'(24'h7fffff));
        write_reg(REG_WINDOW_TOP, BASIS_W'(24'h800000));
        write_reg(REG_VIEW_DISTANCE, BASIS_W'(23'h7fffff));
        write_reg(REG_BASIS_RIGHT, 48'h8000_8000_8000);
        write_reg(REG_BASIS_UP, 48'h7fff_7fff_7fff);
        write_reg(REG_BASIS_BACK, 48'hffff_ffff_ffff);
        send_pixel(0, 0, 13'd4096, 13'd4096);
        send_pixel(12'hfff, 12'hfff, 13'd1, 13'd1);
        send_pixel(12'hfff, 0, 13'd4096, 13'd1);
        end_stream();
        drain();
        write_reg(REG_VIEW_DISTANCE, 0);
        write_reg(REG_WINDOW_LEFT, 0);
        write_reg(REG_WINDOW_RIGHT, 0);
        write_reg(REG_WINDOW_BOTTOM, 0);
        write_reg(REG_WINDOW_TOP, 0);
        write_reg(REG_BASIS_RIGHT, 0);
        send_pixel(5, 7, 10, 10);                  // zero vector
        end_stream();
        drain();
    endtask

    task automatic test_random(int n_sets, int per_set);
        for (int s = 0; s < n_sets; s++) begin
            write_reg(REG_WINDOW_LEFT,   BASIS_W'(24'($urandom)));
            write_reg(REG_WINDOW_RIGHT,  BASIS_W'(24'($urandom)));
            write_reg(REG_WINDOW_BOTTOM, BASIS_W'(24'($urandom)));
            write_reg(REG_WINDOW_TOP,    BASIS_W'(24'($urandom)));
            write_reg(REG_VIEW_DISTANCE, BASIS_W'(23'($urandom)));
            write_reg(REG_BASIS_RIGHT, rand_basis());
            write_reg(REG_BASIS_UP,    rand_basis());
            write_reg(REG_BASIS_BACK,  rand_basis());
            for (int i = 0; i < per_set; i++) begin
                idle_burst();
                if ($urandom_range(0, 3) == 0)
                    send_pixel(12'($urandom), 12'($urandom), 13'($urandom), 13'($urandom));
                else
                    send_pixel(12'($urandom_range(0, 1023)), 12'($urandom_range(0, 1023)),
                               13'($urandom_range(1, 1024)), 13'($urandom_range(1, 1024)));
            end
            end_stream();
            drain();
        end
    endtask

    initial begin
        errors = 0;
        quiet = 0;
        i_rst_n <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel_col <= '0;
        pix_ch.pixel_row <= '0;
        pix_ch.image_width <= 13'd1;
        pix_ch.image_height <= 13'd1;
        cam_left = WIN_LO_RESET;
        cam_right = WIN_HI_RESET;
        cam_bottom = WIN_LO_RESET;
        cam_top = WIN_HI_RESET;
        cam_dist = DIST_RESET;
        cam_rt = RIGHT_RESET;
        cam_up = UP_RESET;
        cam_back = BACK_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_extremes();
        test_random(10, 100);
        quiet = 1;
        test_random(3, 100);
        if (errors == 0)
            $display("** pinhole_primary_ray_direction_core: PASSED **");
        else
            $display("** pinhole_primary_ray_direction_core: FAILED **");
        $finish;
    end
endmodule
